[rtl/utf8_to_utf16_line_decoder_assert.svh]
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 line decoder: assertion macros
// Concurrent checks on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef UTF8_TO_UTF16_LINE_DECODER_ASSERT_SVH
`define UTF8_TO_UTF16_LINE_DECODER_ASSERT_SVH

// ante holds in a cycle -> cons holds in the same cycle
`define U8U16_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// ante holds in a cycle -> cons holds in the next cycle
`define U8U16_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/u8u16_pkg.sv]
// ----------------------------------------------------------------------------
// u8u16_pkg
// Types, register codes and constants of the UTF-8 to UTF-16 line decoder.
// ----------------------------------------------------------------------------
package u8u16_pkg;

    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_NARROW = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPL   = 1'b1;

    localparam logic [15:0] REPL_RESET = 16'd63;
    localparam logic [15:0] SURR_HIGH  = 16'hD800;
    localparam logic [15:0] SURR_LOW   = 16'hDC00;
    localparam logic [20:0] SUPP_BASE  = 21'h010000;
    localparam logic [20:0] BMP_MAX    = 21'h00FFFF;
    localparam logic [20:0] CP_MAX     = 21'h10FFFF;
    localparam logic [20:0] ASCII_END  = 21'h000080;
    localparam logic [20:0] CHAR_CR    = 21'h00000D;
    localparam logic [20:0] CHAR_LF    = 21'h00000A;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_data;
    } in_item_t;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        unit_present;
        logic        line_end;
        logic        bad_sequence;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic [20:0] pcp;
        logic [1:0]  rem;
        logic [1:0]  seq_len;
    } state_t;

    // results of one byte: up to two, num gives how many
    typedef struct packed {
        out_item_t [1:0] res;
        logic [1:0]      num;
    } step_out_t;

endpackage

[rtl/u8u16_stream_if.sv]
// ----------------------------------------------------------------------------
// u8u16_stream_if
// Valid/ready channel carrying one payload item per request.
// ----------------------------------------------------------------------------
interface u8u16_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[rtl/utf8_to_utf16_line_decoder.sv]
// ----------------------------------------------------------------------------
// utf8_to_utf16_line_decoder
// UTF-8 byte stream in, UTF-16 code units and line-end marks out.
// ----------------------------------------------------------------------------
// One byte is accepted per clock while the result queue has room for two
// results. Each accepted byte sits in the input register, where it is
// decoded against the sequence state, and its zero to two results are
// written into a result queue of QUEUE_DEPTH entries (power of two, at
// least 2); the first result is offered once it is written into the queue.
// The output side delivers one result per clock while the receiver is
// ready, so bytes that give two results (surrogate pairs, or a broken
// sequence followed by a new character) need two output transfers and the queue
// absorbs the difference. Carriage returns give no result. Configuration
// writes: index 0 narrow mode, index 1 replacement character.
module utf8_to_utf16_line_decoder #(
    parameter int QUEUE_DEPTH = u8u16_pkg::QUEUE_DEPTH
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [u8u16_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [u8u16_pkg::CFG_DATA_W-1:0] cfg_data,
    u8u16_stream_if.sink                     utf8,
    u8u16_stream_if.source                   utf16
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);
    localparam logic [CNT_W-1:0] ROOM2_C = CNT_W'(QUEUE_DEPTH - 2);

    logic                  narrow_reg;
    logic [15:0]           repl_reg;
    logic                  s1_valid_reg;
    u8u16_pkg::in_item_t   s1_item_reg;
    u8u16_pkg::state_t     st_reg;
    u8u16_pkg::state_t     st_next;
    u8u16_pkg::step_out_t  step;
    u8u16_pkg::out_item_t  q_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]      wr_ptr_reg;
    logic [PTR_W-1:0]      rd_ptr_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [CNT_W-1:0]      cnt_next;
    logic                  s1_fire;
    logic                  in_fire;
    logic                  pop;

    // worst case two results per byte; pops in this cycle are not counted
    assign s1_fire     = s1_valid_reg && (cnt_reg <= ROOM2_C);
    assign utf8.ready  = !s1_valid_reg || s1_fire;
    assign in_fire     = utf8.valid && utf8.ready;
    assign utf16.valid = cnt_reg != '0;
    assign utf16.payload = q_mem[rd_ptr_reg];
    assign pop         = utf16.valid && utf16.ready;
    assign cnt_next    = cnt_reg + (s1_fire ? CNT_W'(step.num) : '0)
                         - (pop ? CNT_W'(1) : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            narrow_reg <= 1'b0;
            repl_reg   <= u8u16_pkg::REPL_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                u8u16_pkg::CFG_NARROW: narrow_reg <= cfg_data[0];
                u8u16_pkg::CFG_REPL:   repl_reg   <= cfg_data[15:0];
                default:               ;
            endcase
        end
    end

    u8u16_decode u_decode (
        .st      (st_reg),
        .item    (s1_item_reg),
        .narrow  (narrow_reg),
        .repl    (repl_reg),
        .st_next (st_next),
        .step    (step)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            st_reg       <= '0;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            cnt_reg      <= '0;
        end
        else
        begin
            if (utf8.ready)
            begin
                s1_valid_reg <= utf8.valid;
            end
            if (s1_fire)
            begin
                st_reg     <= st_next;
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(step.num);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_item_reg <= utf8.payload;
        end
        if (s1_fire && step.num != 2'd0)
        begin
            q_mem[wr_ptr_reg] <= step.res[0];
        end
        if (s1_fire && step.num == 2'd2)
        begin
            q_mem[wr_ptr_reg + PTR_W'(1)] <= step.res[1];
        end
    end

`include "utf8_to_utf16_line_decoder_assert.svh"

    `U8U16_ASSERT_NOW(a_queue_bound, 1'b1, cnt_reg <= DEPTH_C, "result queue overflow")
    `U8U16_ASSERT_NOW(a_rem_in_seq, 1'b1, st_reg.rem <= st_reg.seq_len, "bytes left exceed sequence")
    `U8U16_ASSERT_NEXT(a_eod_clear, s1_fire && s1_item_reg.end_of_data, st_reg.rem == 2'd0, "sequence pending after end of data")
    `U8U16_ASSERT_NEXT(a_pop_count, pop && !s1_fire, cnt_reg == $past(cnt_reg) - CNT_W'(1), "queue count not decremented on pop")

endmodule

[rtl/u8u16_decode.sv]
// ----------------------------------------------------------------------------
// u8u16_decode
// Per-byte decode: next sequence state and up to two UTF-16 results.
// ----------------------------------------------------------------------------
module u8u16_decode (
    input  u8u16_pkg::state_t    st,
    input  u8u16_pkg::in_item_t  item,
    input  logic                 narrow,
    input  logic [15:0]          repl,
    output u8u16_pkg::state_t    st_next,
    output u8u16_pkg::step_out_t step
);

    logic [7:0]            b;
    logic                  pending;
    logic                  take_cont;
    logic [20:0]           acc;
    logic [1:0]            rem_dec;
    logic [20:0]           cp_sel;
    logic [20:0]           supp;
    logic [1:0]            f_num;
    u8u16_pkg::out_item_t  f0;
    u8u16_pkg::out_item_t  f1;
    u8u16_pkg::out_item_t  bad_item;

    assign b         = item.in_byte;
    assign pending   = st.rem != 2'd0;
    assign take_cont = pending && (b[7:6] == 2'b10);
    assign acc       = {st.pcp[14:0], b[5:0]};
    assign rem_dec   = st.rem - 2'd1;
    assign cp_sel    = take_cont ? acc : {13'd0, b};
    assign supp      = cp_sel - u8u16_pkg::SUPP_BASE;
    assign bad_item  = '{code_unit: repl, unit_present: 1'b1, line_end: 1'b0,
                         bad_sequence: 1'b1, last: 1'b0};

    // completed code point -> results
    always_comb
    begin
        f0    = '0;
        f1    = '0;
        f_num = 2'd0;
        if (cp_sel == u8u16_pkg::CHAR_CR)
        begin
            f_num = 2'd0;
        end
        else if (cp_sel == u8u16_pkg::CHAR_LF)
        begin
            f0.line_end = 1'b1;
            f_num       = 2'd1;
        end
        else if ((narrow && cp_sel >= u8u16_pkg::ASCII_END) || cp_sel > u8u16_pkg::CP_MAX)
        begin
            f0    = bad_item;
            f_num = 2'd1;
        end
        else if (cp_sel > u8u16_pkg::BMP_MAX)
        begin
            f0.code_unit    = u8u16_pkg::SURR_HIGH | {6'd0, supp[19:10]};
            f0.unit_present = 1'b1;
            f1.code_unit    = u8u16_pkg::SURR_LOW | {6'd0, cp_sel[9:0]};
            f1.unit_present = 1'b1;
            f_num           = 2'd2;
        end
        else
        begin
            f0.code_unit    = cp_sel[15:0];
            f0.unit_present = 1'b1;
            f_num           = 2'd1;
        end
    end

    always_comb
    begin
        step    = '0;
        st_next = st;
        if (take_cont)
        begin
            if (rem_dec == 2'd0)
            begin
                st_next = '0;
                if (f_num != 2'd0)
                begin
                    step.res[step.num[0]] = f0;
                    step.num              = step.num + 2'd1;
                end
                if (f_num == 2'd2)
                begin
                    step.res[step.num[0]] = f1;
                    step.num              = step.num + 2'd1;
                end
            end
            else
            begin
                st_next.pcp = acc;
                st_next.rem = rem_dec;
            end
        end
        else
        begin
            // broken sequence: flag it, then decode this byte afresh
            if (pending)
            begin
                step.res[step.num[0]] = bad_item;
                step.num              = step.num + 2'd1;
                st_next               = '0;
            end
            case (b) inside
                [8'h00:8'h7F]:
                begin
                    if (f_num != 2'd0)
                    begin
                        step.res[step.num[0]] = f0;
                        step.num              = step.num + 2'd1;
                    end
                end
                [8'hC0:8'hDF]: st_next = '{pcp: {16'd0, b[4:0]}, rem: 2'd1, seq_len: 2'd1};
                [8'hE0:8'hEF]: st_next = '{pcp: {17'd0, b[3:0]}, rem: 2'd2, seq_len: 2'd2};
                [8'hF0:8'hF7]: st_next = '{pcp: {18'd0, b[2:0]}, rem: 2'd3, seq_len: 2'd3};
                default:
                begin
                    // stray continuation or invalid lead
                    step.res[step.num[0]] = bad_item;
                    step.num              = step.num + 2'd1;
                end
            endcase
        end
        // truncated at end of data
        if (item.end_of_data && st_next.rem != 2'd0)
        begin
            step.res[step.num[0]] = bad_item;
            step.num              = step.num + 2'd1;
            st_next               = '0;
        end
        if (step.num != 2'd0)
        begin
            step.res[step.num[1]].last = 1'b1;
        end
    end

endmodule

[sim/utf8_to_utf16_line_decoder_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// utf8_to_utf16_line_decoder_tb
// Self-checking bench for the UTF-8 to UTF-16 line decoder. Each accepted
// byte is decoded by a tracker class that keeps its own sequence state and
// queues the code units and line-end marks it expects. Each result taken
// from the block is compared field by field with the oldest of them.
// Stimulus is a directed run over lead, continuation, broken, truncated,
// oversize and overlong forms, followed by mostly well-formed random text,
// under three idle patterns and a long receiver hold-off.
// ----------------------------------------------------------------------------
module utf8_to_utf16_line_decoder_tb;
    import u8u16_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 300;
    localparam int TAIL_CYCLES    = 8;
    localparam int MAX_REPORTS    = 10;

    class utf16_unit_tracker;
        out_item_t   expected_units[$];
        logic        narrow;
        logic [15:0] repl;
        logic [20:0] pcp;
        logic [1:0]  rem;
        logic [1:0]  seq_len;
        int unsigned mismatches;

        function new();
            narrow     = 1'b0;
            repl       = REPL_RESET;
            mismatches = 0;
            clear_seq();
        endfunction

        function void clear_seq();
            pcp     = '0;
            rem     = '0;
            seq_len = '0;
        endfunction

        function void cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_NARROW)
                narrow = data[0];
            else if (idx == CFG_REPL)
                repl = data;
        endfunction

        function void push_unit(logic [15:0] code, logic present, logic le, logic bad);
            out_item_t u;
            u.code_unit    = code;
            u.unit_present = present;
            u.line_end     = le;
            u.bad_sequence = bad;
            u.last         = 1'b0;
            expected_units.push_back(u);
        endfunction

        function void push_bad();
            push_unit(repl, 1'b1, 1'b0, 1'b1);
        endfunction

        function void emit_cp(logic [20:0] cp);
            logic [20:0] v;
            v = cp - SUPP_BASE;
            if (cp == CHAR_CR)
                return;
            if (cp == CHAR_LF)
                push_unit(16'h0000, 1'b0, 1'b1, 1'b0);
            else if (narrow && cp >= ASCII_END)
                push_bad();
            else if (cp > CP_MAX)
                push_bad();
            else if (cp > BMP_MAX)
            begin
                push_unit(SURR_HIGH | {6'd0, v[19:10]}, 1'b1, 1'b0, 1'b0);
                push_unit(SURR_LOW | {6'd0, cp[9:0]}, 1'b1, 1'b0, 1'b0);
            end
            else
                push_unit(cp[15:0], 1'b1, 1'b0, 1'b0);
        endfunction

        function void start_seq(logic [20:0] payload, logic [1:0] count);
            pcp     = payload;
            rem     = count;
            seq_len = count;
        endfunction

        // decode one accepted byte into the expected results
        function void decode_byte(in_item_t item);
            logic [7:0]  b;
            logic        fresh;
            logic [20:0] cp;
            int          n_prior;
            out_item_t   tail;
            b       = item.in_byte;
            fresh   = 1'b1;
            n_prior = expected_units.size();
            if (rem != 0)
            begin
                if (b[7:6] == 2'b10)
                begin
                    pcp = {pcp[14:0], b[5:0]};
                    rem = rem - 2'd1;
                    if (rem == 0)
                    begin
                        cp = pcp;
                        clear_seq();
                        emit_cp(cp);
                    end
                    fresh = 1'b0;
                end
                else
                begin
                    // sequence broken: flag it, then decode the byte afresh
                    push_bad();
                    clear_seq();
                end
            end
            if (fresh)
            begin
                if (!b[7])
                    emit_cp({13'd0, b});
                else if (!b[6])
                    push_bad();
                else if (!b[5])
                    start_seq({16'd0, b[4:0]}, 2'd1);
                else if (!b[4])
                    start_seq({17'd0, b[3:0]}, 2'd2);
                else if (!b[3])
                    start_seq({18'd0, b[2:0]}, 2'd3);
                else
                    push_bad();
            end
            if (item.end_of_data && rem != 0)
            begin
                push_bad();
                clear_seq();
            end
            if (expected_units.size() > n_prior)
            begin
                tail      = expected_units.pop_back();
                tail.last = 1'b1;
                expected_units.push_back(tail);
            end
        endfunction

        function void check_unit(out_item_t got);
            out_item_t want;
            if (expected_units.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected result unit=%h present=%b le=%b bad=%b last=%b",
                             $time, got.code_unit, got.unit_present, got.line_end,
                             got.bad_sequence, got.last);
                return;
            end
            want = expected_units.pop_front();
            if (got.code_unit !== want.code_unit || got.unit_present !== want.unit_present
                || got.line_end !== want.line_end || got.bad_sequence !== want.bad_sequence
                || got.last !== want.last)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display({"%0t: exp unit=%h present=%b le=%b bad=%b last=%b",
                              " / got unit=%h present=%b le=%b bad=%b last=%b"},
                             $time, want.code_unit, want.unit_present, want.line_end,
                             want.bad_sequence, want.last, got.code_unit, got.unit_present,
                             got.line_end, got.bad_sequence, got.last);
            end
        endfunction

        function int pending();
            return expected_units.size();
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    u8u16_stream_if #(.payload_t(in_item_t))  utf8_ch ();
    u8u16_stream_if #(.payload_t(out_item_t)) utf16_ch ();

    utf8_to_utf16_line_decoder DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .utf8      (utf8_ch),
        .utf16     (utf16_ch)
    );

    utf16_unit_tracker tracker;
    int unsigned src_idle;
    int unsigned rcv_idle;
    int unsigned stall_cycles;
    int unsigned bytes_sent;
    logic        hold_req;
    int unsigned hold_cnt;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // monitor: results first, then the byte request of the same edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (utf16_ch.valid && utf16_ch.ready)
                tracker.check_unit(utf16_ch.payload);
            if (utf8_ch.valid && utf8_ch.ready)
                tracker.decode_byte(utf8_ch.payload);
            if ((utf16_ch.valid && utf16_ch.ready) || (utf8_ch.valid && utf8_ch.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
    end

    initial
    begin
        while (stall_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("Mismatches found");
        $finish;
    end

    // receiver: random back-pressure, or a long hold-off when asked
    initial
    begin
        utf16_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cnt != 0)
            begin
                utf16_ch.ready = 1'b0;
                hold_cnt--;
            end
            else if (hold_req)
            begin
                hold_req       = 1'b0;
                hold_cnt       = HOLD_CYCLES;
                utf16_ch.ready = 1'b0;
            end
            else
                utf16_ch.ready = ($urandom_range(99) >= rcv_idle);
        end
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_byte(input logic [7:0] b, input logic eod);
        in_item_t item;
        item.in_byte     = b;
        item.end_of_data = eod;
        while ($urandom_range(99) < src_idle)
        begin
            utf8_ch.valid = 1'b0;
            @(negedge clk);
        end
        utf8_ch.valid   = 1'b1;
        utf8_ch.payload = item;
        do
            @(posedge clk);
        while (!utf8_ch.ready);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_data(input logic [7:0] b);
        send_byte(b, $urandom_range(99) < 3);
    endtask

    function automatic logic [7:0] rand_cont();
        return 8'h80 | 8'($urandom_range(63));
    endfunction

    task automatic send_random_char();
        int unsigned kind;
        int unsigned len;
        int unsigned k;
        logic [7:0]  b;
        kind = $urandom_range(99);
        if (kind < 8)
            send_data(CHAR_LF[7:0]);
        else if (kind < 12)
            send_data(CHAR_CR[7:0]);
        else if (kind < 35)
            send_data(8'($urandom_range(127)));
        else if (kind < 80)
        begin
            len = (kind < 50) ? 1 : (kind < 65) ? 2 : 3;
            case (len)
                1: b = 8'hC0 | 8'($urandom_range(31));
                2: b = 8'hE0 | 8'($urandom_range(15));
                default: b = 8'hF0 | 8'($urandom_range(7));
            endcase
            send_data(b);
            for (k = 0; k < len; k++)
                send_data(rand_cont());
        end
        else if (kind < 90)
            send_data(8'($urandom_range(255)));
        else
        begin
            // lead, too few continuations, then a byte that breaks it
            len = $urandom_range(1, 3);
            case (len)
                1: b = 8'hC0 | 8'($urandom_range(31));
                2: b = 8'hE0 | 8'($urandom_range(15));
                default: b = 8'hF0 | 8'($urandom_range(7));
            endcase
            send_data(b);
            for (k = 1; k < len; k++)
                if ($urandom_range(1))
                    send_data(rand_cont());
            b = 8'($urandom_range(255));
            if (b[7:6] == 2'b10)
                b[6] = 1'b1;
            send_data(b);
        end
    endtask

    task automatic send_random(input int unsigned count);
        int unsigned start;
        start = bytes_sent;
        while (bytes_sent - start < count)
            send_random_char();
    endtask

    task automatic wait_idle();
        utf8_ch.valid = 1'b0;
        while (tracker.pending() != 0)
            @(negedge clk);
        // a trailing CR leaves nothing to wait for, so give it time to clear
        repeat (TAIL_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        tracker.cfg_write(idx, data);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    initial
    begin
        tracker         = new();
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        utf8_ch.valid   = 1'b0;
        utf8_ch.payload = '0;
        stall_cycles    = 0;
        bytes_sent      = 0;
        hold_req        = 1'b0;
        hold_cnt        = 0;
        src_idle        = 19;
        rcv_idle        = 66;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed, reset configuration
        send_byte(8'h00, 1'b0);  send_byte(8'h7F, 1'b0);
        send_byte(8'h0D, 1'b0);  send_byte(8'h0A, 1'b0);
        send_byte(8'hC3, 1'b0);  send_byte(8'hA9, 1'b0);
        send_byte(8'hE2, 1'b0);  send_byte(8'h82, 1'b0);  send_byte(8'hAC, 1'b0);
        send_byte(8'hF0, 1'b0);  send_byte(8'h9F, 1'b0);
        send_byte(8'h98, 1'b0);  send_byte(8'h80, 1'b0);
        // above the last code point
        send_byte(8'hF7, 1'b0);  send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);  send_byte(8'hBF, 1'b0);
        send_byte(8'h80, 1'b0);  send_byte(8'hFF, 1'b0);
        // broken sequences: by ASCII and by an invalid lead
        send_byte(8'hC3, 1'b0);  send_byte(8'h41, 1'b0);
        send_byte(8'hC3, 1'b0);  send_byte(8'hF8, 1'b0);
        // truncated at end of data, then overlong LF and overlong CR
        send_byte(8'hE2, 1'b1);
        send_byte(8'hC0, 1'b0);  send_byte(8'h8A, 1'b0);
        send_byte(8'hC0, 1'b0);  send_byte(8'h8D, 1'b0);
        send_random(150);

        wait_idle();
        write_reg(CFG_NARROW, 16'h0001);
        write_reg(CFG_REPL, 16'hFFFF);
        send_byte(8'hC3, 1'b0);  send_byte(8'hA9, 1'b0);
        send_byte(8'hC1, 1'b0);  send_byte(8'h81, 1'b0);
        send_byte(8'hF0, 1'b0);  send_byte(8'h9F, 1'b0);
        send_byte(8'h98, 1'b0);  send_byte(8'h80, 1'b1);
        send_random(150);

        wait_idle();
        src_idle = 66;
        rcv_idle = 19;
        write_reg(CFG_NARROW, 16'h0000);
        write_reg(CFG_REPL, 16'h0000);
        send_random(300);

        wait_idle();
        src_idle = 0;
        rcv_idle = 0;
        write_reg(CFG_REPL, 16'($urandom_range(65535)));
        hold_req = 1'b1;
        send_random(150);

        wait_idle();
        write_reg(CFG_NARROW, 16'h0001);
        write_reg(CFG_REPL, 16'hFFFD);
        send_random(150);

        wait_idle();
        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

[filelist.f]
+incdir+rtl
rtl/u8u16_pkg.sv
rtl/u8u16_stream_if.sv
rtl/u8u16_decode.sv
rtl/utf8_to_utf16_line_decoder.sv
sim/utf8_to_utf16_line_decoder_tb.sv
